### design/rgbpk_pkg.sv
// Shared types, constants and helper functions of the RGB to masked pixel packer.
package rgbpk_pkg;

   localparam int LEVEL_BITS         = 8;
   localparam int PIXEL_WORD_BITS    = 32;
   localparam int DEFAULT_PIXEL_BITS = 32;
   localparam int MASK_COUNT         = 3;
   localparam int CSR_ADDR_BITS      = 4;
   localparam int WIDTH_BITS         = 6;   // 0..32 set bits
   localparam int SHIFT_BITS         = 5;   // lowest set bit 0..31
   localparam int QUOT_BITS          = 25;  // floor(2^32/255) needs 25 bits
   localparam int REM_BITS           = 7;   // (2^(w mod 8)) - 1, at most 127

   localparam logic [PIXEL_WORD_BITS-1:0] RED_MASK_RESET   = 32'h00FF_0000;
   localparam logic [PIXEL_WORD_BITS-1:0] GREEN_MASK_RESET = 32'h0000_FF00;
   localparam logic [PIXEL_WORD_BITS-1:0] BLUE_MASK_RESET  = 32'h0000_00FF;

   // Register index, taken from the word-aligned CSR address
   typedef enum logic [1:0] {
      CSR_RED_MASK   = 2'd0,
      CSR_GREEN_MASK = 2'd1,
      CSR_BLUE_MASK  = 2'd2
   } csr_index_type;

   // Mask plus the figures derived from it when it is written.
   // 2^width = 255*quot + (rem_m1 + 1), so
   // (v*(2^width-1)+127)/255 = v*quot + (v*rem_m1+127)/255.
   typedef struct packed {
      logic [PIXEL_WORD_BITS-1:0] mask;
      logic [WIDTH_BITS-1:0]      width;
      logic [SHIFT_BITS-1:0]      shift;
      logic [QUOT_BITS-1:0]       quot;
      logic [REM_BITS-1:0]        rem_m1;
   } field_cfg_type;

   function automatic field_cfg_type derive_cfg(input logic [PIXEL_WORD_BITS-1:0] mask);
      field_cfg_type              cfg;
      logic [3:0]                 byte_ones [4];
      logic [PIXEL_WORD_BITS-1:0] lowest;
      logic [WIDTH_BITS-1:0]      ones;
      logic [SHIFT_BITS-1:0]      pos;
      logic [QUOT_BITS-1:0]       quot;
      logic [7:0]                 pow;
      for (int b = 0; b < 4; b++) begin
         byte_ones[b] = '0;
         for (int j = 0; j < 8; j++) begin
            byte_ones[b] = byte_ones[b] + 4'(mask[8*b+j]);
         end
      end
      ones = WIDTH_BITS'(byte_ones[0]) + WIDTH_BITS'(byte_ones[1])
           + WIDTH_BITS'(byte_ones[2]) + WIDTH_BITS'(byte_ones[3]);
      // isolate the lowest set bit, then encode its position
      lowest = mask & (~mask + 32'd1);
      pos    = '0;
      for (int j = 0; j < PIXEL_WORD_BITS; j++) begin
         if (lowest[j]) begin
            pos = pos | SHIFT_BITS'(j);
         end
      end
      // floor(2^w/255) = sum of 2^(w-8k) over 8k <= w
      quot = '0;
      for (int k = 1; k <= 4; k++) begin
         if (ones >= WIDTH_BITS'(8 * k)) begin
            quot = quot + (QUOT_BITS'(1) << (ones - WIDTH_BITS'(8 * k)));
         end
      end
      pow        = 8'd1 << ones[2:0];
      cfg.mask   = mask;
      cfg.width  = ones;
      cfg.shift  = pos;
      cfg.quot   = quot;
      cfg.rem_m1 = REM_BITS'(pow - 8'd1);
      return cfg;
   endfunction

endpackage

### design/rgb_to_masked_pixel_packer_core.sv
// RGB888 to masked truecolour pixel packer: top level with CSRs and two-stage datapath.
//
// Takes one colour word (8-bit red, green and blue levels) and returns one packed pixel word.
// Each component is scaled to its field with rounding, (v*(2^w-1)+127)/255, where w is the
// number of set bits in that colour's field mask, shifted up to the mask's lowest set bit,
// ANDed with the mask, and the three fields are ORed; bits at and above PIXEL_BITS are
// cleared. Throughput is one word per clock while rsp_stall does not hold the result register.
// A word is captured in the input register when accepted and moves to the result register
// when that register is free, which raises rsp_valid. The path between them is one
// 8x25-bit multiply and add per colour lane, followed by a barrel shift and the mask.
// Field widths, shifts and the scaling constants are worked out when a mask is written, so
// a mask change is seen by the next word. Masks are written through the APB-style CSR
// port at byte addresses 0 (red), 4 (green) and 8 (blue), decoded from paddr[3:2]; writes to
// 12 to 15 are dropped and read back as zero. Write masks only while no word is in flight.
module rgb_to_masked_pixel_packer_core #(
   parameter int PIXEL_BITS = rgbpk_pkg::DEFAULT_PIXEL_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // colour words in
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [rgbpk_pkg::LEVEL_BITS-1:0]         req_red_level,
   input  logic [rgbpk_pkg::LEVEL_BITS-1:0]         req_green_level,
   input  logic [rgbpk_pkg::LEVEL_BITS-1:0]         req_blue_level,
   // packed pixel words out
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [rgbpk_pkg::PIXEL_WORD_BITS-1:0]    rsp_packed_pixel,
   // CSR port
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [rgbpk_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [rgbpk_pkg::PIXEL_WORD_BITS-1:0]    csr_pwdata,
   output logic [rgbpk_pkg::PIXEL_WORD_BITS-1:0]    csr_prdata,
   output logic                                     csr_pready
);

   // Bits of the pixel word that survive the PIXEL_BITS cut
   localparam int KeepBits = (PIXEL_BITS < rgbpk_pkg::PIXEL_WORD_BITS) ?
                             PIXEL_BITS : rgbpk_pkg::PIXEL_WORD_BITS;
   localparam int LaneCount = rgbpk_pkg::MASK_COUNT;
   localparam int ProdBits  = rgbpk_pkg::LEVEL_BITS + rgbpk_pkg::QUOT_BITS;
   localparam int FracBits  = 16;

   // ---------------------------------------------------------------------------------------
   // CSRs: masks with their derived figures
   // ---------------------------------------------------------------------------------------
   rgbpk_pkg::field_cfg_type cfg_ff [LaneCount];
   rgbpk_pkg::field_cfg_type cfg_in [LaneCount];
   rgbpk_pkg::csr_index_type csr_index;
   logic                     csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = rgbpk_pkg::csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      for (int i = 0; i < LaneCount; i++) begin
         cfg_in[i] = cfg_ff[i];
      end
      if (csr_write) begin
         unique case (csr_index)
            rgbpk_pkg::CSR_RED_MASK: begin
               cfg_in[0] = rgbpk_pkg::derive_cfg(csr_pwdata);
            end
            rgbpk_pkg::CSR_GREEN_MASK: begin
               cfg_in[1] = rgbpk_pkg::derive_cfg(csr_pwdata);
            end
            rgbpk_pkg::CSR_BLUE_MASK: begin
               cfg_in[2] = rgbpk_pkg::derive_cfg(csr_pwdata);
            end
            default: begin
               // unmapped address: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[0] <= rgbpk_pkg::derive_cfg(rgbpk_pkg::RED_MASK_RESET);
         cfg_ff[1] <= rgbpk_pkg::derive_cfg(rgbpk_pkg::GREEN_MASK_RESET);
         cfg_ff[2] <= rgbpk_pkg::derive_cfg(rgbpk_pkg::BLUE_MASK_RESET);
      end else begin
         for (int i = 0; i < LaneCount; i++) begin
            cfg_ff[i] <= cfg_in[i];
         end
      end
   end

   always_comb begin
      unique case (csr_index)
         rgbpk_pkg::CSR_RED_MASK:   csr_prdata = cfg_ff[0].mask;
         rgbpk_pkg::CSR_GREEN_MASK: csr_prdata = cfg_ff[1].mask;
         rgbpk_pkg::CSR_BLUE_MASK:  csr_prdata = cfg_ff[2].mask;
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // Handshake: input register feeds result register; the result register is the skid
   // point, so a new word is taken while a finished pixel waits.
   // ---------------------------------------------------------------------------------------
   logic in_valid_ff, in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept, out_free, out_load;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign out_load   = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------------------------------
   logic [rgbpk_pkg::LEVEL_BITS-1:0] level_ff [LaneCount];

   always_ff @(posedge clock) begin
      if (req_accept) begin
         level_ff[0] <= req_red_level;
         level_ff[1] <= req_green_level;
         level_ff[2] <= req_blue_level;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Scale and place, one lane per colour.
   // scaled = v*quot + (v*rem_m1 + 127)/255; the small term is below 2^15, where
   // x/255 = (x + (x>>8) + 1) >> 8 holds exactly.
   // ---------------------------------------------------------------------------------------
   logic [ProdBits-1:0]                       lane_prod   [LaneCount];
   logic [FracBits-1:0]                       lane_small  [LaneCount];
   logic [FracBits-1:0]                       lane_frac   [LaneCount];
   logic [ProdBits-1:0]                       lane_scaled [LaneCount];
   logic [rgbpk_pkg::PIXEL_WORD_BITS-1:0]     lane_placed [LaneCount];
   logic [rgbpk_pkg::PIXEL_WORD_BITS-1:0]     pixel_full;

   always_comb begin
      pixel_full = '0;
      for (int i = 0; i < LaneCount; i++) begin
         lane_prod[i]   = ProdBits'(level_ff[i]) * ProdBits'(cfg_ff[i].quot);
         lane_small[i]  = FracBits'(level_ff[i]) * FracBits'(cfg_ff[i].rem_m1)
                        + FracBits'(127);
         lane_frac[i]   = (lane_small[i] + (lane_small[i] >> 8) + FracBits'(1)) >> 8;
         lane_scaled[i] = lane_prod[i] + ProdBits'(lane_frac[i]);
         lane_placed[i] = (lane_scaled[i][rgbpk_pkg::PIXEL_WORD_BITS-1:0] << cfg_ff[i].shift)
                        & cfg_ff[i].mask;
         pixel_full     = pixel_full | lane_placed[i];
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------------------------
   logic [KeepBits-1:0] pixel_ff;

   always_ff @(posedge clock) begin
      if (out_load) begin
         pixel_ff <= pixel_full[KeepBits-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_packed_pixel = rgbpk_pkg::PIXEL_WORD_BITS'(pixel_ff);

   // ---------------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------------
   for (genvar g = 0; g < LaneCount; g++) begin : g_cfg_check
      a_width_matches_mask : assert property (@(posedge clock) disable iff (reset)
         cfg_ff[g].width == rgbpk_pkg::WIDTH_BITS'($countones(cfg_ff[g].mask)))
         else $error("field width out of step with mask");
      a_shift_on_set_bit : assert property (@(posedge clock) disable iff (reset)
         cfg_ff[g].mask != '0 |-> cfg_ff[g].mask[cfg_ff[g].shift])
         else $error("field shift not on a set mask bit");
   end

   a_advance_gives_result : assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("word moved to result register but no result shown");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

endmodule
